// ===== design/ptap_pkg.sv =====
// ptap_pkg: shared widths, register codes, payload structs and the arctangent table
// for the pan/tilt angle pipeline. No dependencies.
`default_nettype none

package ptap_pkg;

  // field widths
  localparam int POS_W      = 16;
  localparam int SCALE_W    = 18;
  localparam int OFF_W      = 16;
  localparam int HGT_W      = 16;
  localparam int PAN_W      = 15;
  localparam int TILT_W     = 13;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 18;

  // register codes
  localparam logic [CFG_IDX_W-1:0] CFG_SCALE        = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_X_OFFSET     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_Y_OFFSET     = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MOUNT_HEIGHT = 2'd3;

  localparam logic [SCALE_W-1:0] SCALE_RST  = 18'd714;
  localparam logic [HGT_W-1:0]   HEIGHT_RST = 16'd2816;

  // internal widths
  localparam int PROD_W = 35;  // pixel times scale
  localparam int MAG_W  = 16;  // |metres| in Q8.8
  localparam int ARG_W  = 24;  // cordic operands, Q8.16
  localparam int CORD_W = 27;  // cordic x/y with gain headroom
  localparam int ATAN_W = 21;
  localparam int ZACC_W = 22;  // angle accumulator, 1/16384 degree
  localparam int ANG_W  = 13;  // first quadrant angle, 1/64 degree
  localparam int SQ_W   = 32;
  localparam int RAD_W  = 48;  // radicand, (x^2 + y^2) << 16
  localparam int ROOT_W = 24;

  localparam logic [ANG_W-1:0] QUARTER = 13'd5760;

  localparam int CORDIC_STAGES_DEF = 16;
  localparam int ATAN_TAB_LEN      = 24;

  typedef struct packed {
    logic [MAG_W-1:0] ax;
    logic [MAG_W-1:0] ay;
    logic             x_neg;
    logic             y_neg;
    logic             origin;
    logic             clip;
  } ptap_pos_t;

  typedef struct packed {
    logic signed [PAN_W-1:0] pan;
    logic                    clip;
  } ptap_res_t;

  // atan(2^-i) in 1/16384 degree, rounded
  function automatic logic [ATAN_W-1:0] atan_entry(input int unsigned idx);
    logic [ATAN_W-1:0] val;
    case (idx)
      0:       val = 21'd737280;
      1:       val = 21'd435242;
      2:       val = 21'd229970;
      3:       val = 21'd116736;
      4:       val = 21'd58595;
      5:       val = 21'd29326;
      6:       val = 21'd14667;
      7:       val = 21'd7334;
      8:       val = 21'd3667;
      9:       val = 21'd1833;
      10:      val = 21'd917;
      11:      val = 21'd458;
      12:      val = 21'd229;
      13:      val = 21'd115;
      14:      val = 21'd57;
      15:      val = 21'd29;
      16:      val = 21'd14;
      17:      val = 21'd7;
      18:      val = 21'd4;
      19:      val = 21'd2;
      20:      val = 21'd1;
      default: val = '0;
    endcase
    return val;
  endfunction

endpackage

`default_nettype wire

// ===== design/ptap_front.sv =====
// ptap_front: two-stage scaling of pixel position to saturated Q8.8 metres,
// with magnitudes, signs and clip flag. Depends on ptap_pkg.
`default_nettype none

module ptap_front (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [ptap_pkg::POS_W-1:0]   in_pos_x,
  input  logic signed [ptap_pkg::POS_W-1:0]   in_pos_y,
  input  logic        [ptap_pkg::SCALE_W-1:0] scale,
  input  logic signed [ptap_pkg::OFF_W-1:0]   x_offset,
  input  logic signed [ptap_pkg::OFF_W-1:0]   y_offset,
  output logic                                out_valid,
  input  logic                                out_ready,
  output ptap_pkg::ptap_pos_t                 out_pos
);
  import ptap_pkg::*;

  localparam int NST = 2;

  logic [NST-1:0] v_r, v_nxt, v_in;
  logic [NST:0]   en;

  logic signed [PROD_W-1:0] prod_x_r, prod_y_r;
  ptap_pos_t                pos_r, pos_nxt;

  // round, subtract offset, saturate; returns {clip, value}
  function automatic logic [MAG_W:0] to_metres(input logic signed [PROD_W-1:0] prod,
                                               input logic signed [OFF_W-1:0]  off);
    logic signed [PROD_W:0]   rnd;
    logic signed [PROD_W-8:0] sh;
    logic signed [PROD_W-7:0] diff;
    logic                     in_rng;
    logic [MAG_W-1:0]         val;
    rnd    = $signed({prod[PROD_W-1], prod}) + (PROD_W+1)'(128);
    sh     = rnd[PROD_W:8];
    diff   = $signed({sh[PROD_W-8], sh})
           - $signed({{(PROD_W-6-OFF_W){off[OFF_W-1]}}, off});
    in_rng = (&diff[PROD_W-7:MAG_W-1]) | ~(|diff[PROD_W-7:MAG_W-1]);
    if (in_rng) begin
      val = diff[MAG_W-1:0];
    end else if (diff[PROD_W-7]) begin
      val = {1'b1, {(MAG_W-1){1'b0}}};
    end else begin
      val = {1'b0, {(MAG_W-1){1'b1}}};
    end
    return {~in_rng, val};
  endfunction

  assign en[NST]  = out_ready;
  assign en[1]    = ~v_r[1] | en[2];
  assign en[0]    = ~v_r[0] | en[1];
  assign in_ready = en[0];

  assign v_in  = {v_r[NST-2:0], in_valid};
  assign v_nxt = (en[NST-1:0] & v_in) | (~en[NST-1:0] & v_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      prod_x_r <= PROD_W'(in_pos_x) * PROD_W'($signed({1'b0, scale}));
      prod_y_r <= PROD_W'(in_pos_y) * PROD_W'($signed({1'b0, scale}));
    end
  end

  always_comb begin
    logic [MAG_W:0] mx, my;
    mx = to_metres(prod_x_r, x_offset);
    my = to_metres(prod_y_r, y_offset);
    pos_nxt.x_neg  = mx[MAG_W-1];
    pos_nxt.y_neg  = my[MAG_W-1];
    pos_nxt.ax     = mx[MAG_W-1] ? (~mx[MAG_W-1:0] + 1'b1) : mx[MAG_W-1:0];
    pos_nxt.ay     = my[MAG_W-1] ? (~my[MAG_W-1:0] + 1'b1) : my[MAG_W-1:0];
    pos_nxt.origin = (mx[MAG_W-1:0] == '0) && (my[MAG_W-1:0] == '0);
    pos_nxt.clip   = mx[MAG_W] | my[MAG_W];
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      pos_r <= pos_nxt;
    end
  end

  assign out_valid = v_r[NST-1];
  assign out_pos   = pos_r;

endmodule

`default_nettype wire

// ===== design/ptap_cordic.sv =====
// ptap_cordic: pipelined vectoring cordic giving the first-quadrant angle of (a, b)
// in 1/64 degree, one rotation per stage, plus a rounding stage. Depends on ptap_pkg.
`default_nettype none

module ptap_cordic #(
  parameter int STAGES = ptap_pkg::CORDIC_STAGES_DEF,
  parameter int SIDE_W = 1
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [ptap_pkg::ARG_W-1:0]        in_a,
  input  logic [ptap_pkg::ARG_W-1:0]        in_b,
  input  logic [SIDE_W-1:0]                 in_side,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [ptap_pkg::ANG_W-1:0]        out_angle,
  output logic [SIDE_W-1:0]                 out_side
);
  import ptap_pkg::*;

  localparam int NST = STAGES + 1;
  localparam logic signed [ZACC_W-8:0] ZQ_MAX = (ZACC_W-7)'(QUARTER);

  logic [NST-1:0] v_r, v_nxt, v_in;
  logic [NST:0]   en;

  logic signed [CORD_W-1:0] x_r [STAGES];
  logic signed [CORD_W-1:0] y_r [STAGES];
  logic signed [ZACC_W-1:0] z_r [STAGES];
  logic                     za_r [STAGES];
  logic                     zb_r [STAGES];
  logic [SIDE_W-1:0]        side_r [NST];
  logic [ANG_W-1:0]         angle_r, angle_nxt;

  assign en[NST]  = out_ready;
  assign in_ready = en[0];

  assign v_in  = {v_r[NST-2:0], in_valid};
  assign v_nxt = (en[NST-1:0] & v_in) | (~en[NST-1:0] & v_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  genvar k;
  generate
    for (k = 0; k < NST; k++) begin : g_en
      assign en[k] = ~v_r[k] | en[k+1];
    end

    for (k = 0; k < STAGES; k++) begin : g_stage
      logic signed [CORD_W-1:0] xi, yi, nx, ny;
      logic signed [ZACC_W-1:0] zi, nz, da;
      logic                     fa, fb;
      logic [SIDE_W-1:0]        si;

      if (k == 0) begin : g_first
        assign xi = $signed({{(CORD_W-ARG_W){1'b0}}, in_a});
        assign yi = $signed({{(CORD_W-ARG_W){1'b0}}, in_b});
        assign zi = '0;
        assign fa = (in_a == '0);
        assign fb = (in_b == '0);
        assign si = in_side;
      end else begin : g_next
        assign xi = x_r[k-1];
        assign yi = y_r[k-1];
        assign zi = z_r[k-1];
        assign fa = za_r[k-1];
        assign fb = zb_r[k-1];
        assign si = side_r[k-1];
      end

      assign da = $signed({1'b0, atan_entry(k)});

      // rotate towards the x axis
      always_comb begin
        if (!yi[CORD_W-1]) begin
          nx = xi + (yi >>> k);
          ny = yi - (xi >>> k);
          nz = zi + da;
        end else begin
          nx = xi - (yi >>> k);
          ny = yi + (xi >>> k);
          nz = zi - da;
        end
      end

      always_ff @(posedge clk) begin
        if (en[k]) begin
          x_r[k]    <= nx;
          y_r[k]    <= ny;
          z_r[k]    <= nz;
          za_r[k]   <= fa;
          zb_r[k]   <= fb;
          side_r[k] <= si;
        end
      end
    end
  endgenerate

  // round to 1/64 degree, clamp to the quadrant, axis cases override
  always_comb begin
    logic signed [ZACC_W:0]   zsum;
    logic signed [ZACC_W-8:0] zq;
    zsum = $signed({z_r[STAGES-1][ZACC_W-1], z_r[STAGES-1]}) + (ZACC_W+1)'(128);
    zq   = zsum[ZACC_W:8];
    if (zb_r[STAGES-1]) begin
      angle_nxt = '0;
    end else if (za_r[STAGES-1]) begin
      angle_nxt = QUARTER;
    end else if (zq[ZACC_W-8]) begin
      angle_nxt = '0;
    end else if (zq > ZQ_MAX) begin
      angle_nxt = QUARTER;
    end else begin
      angle_nxt = zq[ANG_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en[STAGES]) begin
      angle_r        <= angle_nxt;
      side_r[STAGES] <= side_r[STAGES-1];
    end
  end

  assign out_valid = v_r[NST-1];
  assign out_angle = angle_r;
  assign out_side  = side_r[NST-1];

endmodule

`default_nettype wire

// ===== design/ptap_isqrt.sv =====
// ptap_isqrt: pipelined range computation, floor(sqrt((ax^2 + ay^2) << 16)),
// squares, a sum stage, then one root bit per stage. Depends on ptap_pkg.
`default_nettype none

module ptap_isqrt #(
  parameter int SIDE_W = 1
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [ptap_pkg::MAG_W-1:0]    in_ax,
  input  logic [ptap_pkg::MAG_W-1:0]    in_ay,
  input  logic [SIDE_W-1:0]             in_side,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [ptap_pkg::ROOT_W-1:0]   out_root,
  output logic [SIDE_W-1:0]             out_side
);
  import ptap_pkg::*;

  localparam int NST = ROOT_W + 2;
  localparam int T_W = RAD_W + 2;

  logic [NST-1:0] v_r, v_nxt, v_in;
  logic [NST:0]   en;

  logic [SQ_W-1:0]   sq_x_r, sq_y_r;
  logic [RAD_W-1:0]  rad_r;
  logic [RAD_W-1:0]  rem_r  [ROOT_W];
  logic [ROOT_W-1:0] root_r [ROOT_W];
  logic [SIDE_W-1:0] side_r [NST];

  assign en[NST]  = out_ready;
  assign in_ready = en[0];

  assign v_in  = {v_r[NST-2:0], in_valid};
  assign v_nxt = (en[NST-1:0] & v_in) | (~en[NST-1:0] & v_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      sq_x_r    <= SQ_W'(in_ax) * SQ_W'(in_ax);
      sq_y_r    <= SQ_W'(in_ay) * SQ_W'(in_ay);
      side_r[0] <= in_side;
    end
  end

  // both squares are at most 2^30, so the sum fits
  always_ff @(posedge clk) begin
    if (en[1]) begin
      rad_r     <= {(sq_x_r + sq_y_r), {(RAD_W-SQ_W){1'b0}}};
      side_r[1] <= side_r[0];
    end
  end

  genvar k, j;
  generate
    for (k = 0; k < NST; k++) begin : g_en
      assign en[k] = ~v_r[k] | en[k+1];
    end

    for (j = 0; j < ROOT_W; j++) begin : g_bit
      localparam int KB = ROOT_W - 1 - j;
      logic [RAD_W-1:0]  ri, rn;
      logic [ROOT_W-1:0] qi, qn;
      logic [T_W-1:0]    trial;
      logic              take;

      if (j == 0) begin : g_first
        assign ri = rad_r;
        assign qi = '0;
      end else begin : g_next
        assign ri = rem_r[j-1];
        assign qi = root_r[j-1];
      end

      // (q + 2^kb)^2 - q^2 = q * 2^(kb+1) + 2^(2kb)
      assign trial = (T_W'(qi) << (KB + 1)) + (T_W'(1) << (2 * KB));
      assign take  = ({2'b00, ri} >= trial);
      assign rn    = take ? (ri - trial[RAD_W-1:0]) : ri;
      assign qn    = take ? (qi | (ROOT_W'(1) << KB)) : qi;

      always_ff @(posedge clk) begin
        if (en[j+2]) begin
          rem_r[j]    <= rn;
          root_r[j]   <= qn;
          side_r[j+2] <= side_r[j+1];
        end
      end
    end
  endgenerate

  assign out_valid = v_r[NST-1];
  assign out_root  = root_r[ROOT_W-1];
  assign out_side  = side_r[NST-1];

endmodule

`default_nettype wire

// ===== design/pan_tilt_angle_from_position_core.sv =====
// Throughput: one request per cycle while results are taken; every stage has its own
// valid bit and load enable, so a stalled result only holds the stages that are full
// behind it.
// Reset (synchronous, active low): empties the pipeline and loads the register defaults.
// Pipeline: scaling (2) -> pan cordic (CORDIC_STAGES + 1) -> range root (26)
//           -> tilt cordic (CORDIC_STAGES + 1); the tilt cordic's last stage is the output.
`default_nettype none

module pan_tilt_angle_from_position_core #(
  parameter int CORDIC_STAGES = ptap_pkg::CORDIC_STAGES_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  // position requests
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic signed [ptap_pkg::POS_W-1:0]      in_pos_x,
  input  logic signed [ptap_pkg::POS_W-1:0]      in_pos_y,
  // angle results
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic signed [ptap_pkg::PAN_W-1:0]      out_pan,
  output logic        [ptap_pkg::TILT_W-1:0]     out_tilt,
  output logic                                   out_clipped,
  // register writes
  input  logic                                   cfg_we,
  input  logic        [ptap_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic        [ptap_pkg::CFG_DATA_W-1:0] cfg_data
);
  import ptap_pkg::*;

  localparam int POS_SIDE_W = $bits(ptap_pos_t);
  localparam int RES_SIDE_W = $bits(ptap_res_t);

  localparam logic signed [PAN_W-1:0] PAN_QUARTER = 15'sd5760;
  localparam logic signed [PAN_W-1:0] PAN_HALF    = 15'sd11520;

  // configuration registers: user writes only while the pipeline is empty, unenforced
  logic        [SCALE_W-1:0] scale_r;
  logic signed [OFF_W-1:0]   x_offset_r;
  logic signed [OFF_W-1:0]   y_offset_r;
  logic        [HGT_W-1:0]   mount_height_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r        <= SCALE_RST;
      x_offset_r     <= '0;
      y_offset_r     <= '0;
      mount_height_r <= HEIGHT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SCALE:        scale_r        <= cfg_data[SCALE_W-1:0];
        CFG_X_OFFSET:     x_offset_r     <= cfg_data[OFF_W-1:0];
        CFG_Y_OFFSET:     y_offset_r     <= cfg_data[OFF_W-1:0];
        CFG_MOUNT_HEIGHT: mount_height_r <= cfg_data[HGT_W-1:0];
        default: ;
      endcase
    end
  end

  // pixel position to saturated metres
  logic      fr_valid, fr_ready;
  ptap_pos_t fr_pos;

  ptap_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_pos_x  (in_pos_x),
    .in_pos_y  (in_pos_y),
    .scale     (scale_r),
    .x_offset  (x_offset_r),
    .y_offset  (y_offset_r),
    .out_valid (fr_valid),
    .out_ready (fr_ready),
    .out_pos   (fr_pos)
  );

  // first-quadrant pan angle on the magnitudes, both promoted to Q8.16
  logic                  pc_valid, pc_ready;
  logic [ANG_W-1:0]      pc_angle;
  logic [POS_SIDE_W-1:0] pc_side;
  ptap_pos_t             pc_pos;

  ptap_cordic #(
    .STAGES (CORDIC_STAGES),
    .SIDE_W (POS_SIDE_W)
  ) u_pan_cordic (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (fr_valid),
    .in_ready  (fr_ready),
    .in_a      ({fr_pos.ax, 8'd0}),
    .in_b      ({fr_pos.ay, 8'd0}),
    .in_side   (fr_pos),
    .out_valid (pc_valid),
    .out_ready (pc_ready),
    .out_angle (pc_angle),
    .out_side  (pc_side)
  );

  assign pc_pos = ptap_pos_t'(pc_side);

  // quadrant fix-up: mirror about the y axis for negative x, negate for negative y;
  // the origin reads as straight ahead at 90 degrees
  ptap_res_t        pan_res;
  logic signed [PAN_W-1:0] pan_a;

  assign pan_a = $signed({{(PAN_W-ANG_W){1'b0}}, pc_angle});

  always_comb begin
    pan_res.clip = pc_pos.clip;
    if (pc_pos.origin) begin
      pan_res.pan = PAN_QUARTER;
    end else if (!pc_pos.x_neg) begin
      pan_res.pan = pc_pos.y_neg ? -pan_a : pan_a;
    end else begin
      pan_res.pan = pc_pos.y_neg ? (pan_a - PAN_HALF) : (PAN_HALF - pan_a);
    end
  end

  // ground range in Q8.16
  logic                  sq_valid, sq_ready;
  logic [ROOT_W-1:0]     sq_root;
  logic [RES_SIDE_W-1:0] sq_side;

  ptap_isqrt #(
    .SIDE_W (RES_SIDE_W)
  ) u_isqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (pc_valid),
    .in_ready  (pc_ready),
    .in_ax     (pc_pos.ax),
    .in_ay     (pc_pos.ay),
    .in_side   (pan_res),
    .out_valid (sq_valid),
    .out_ready (sq_ready),
    .out_root  (sq_root),
    .out_side  (sq_side)
  );

  // tilt = atan(range / height); zero range gives zero, zero height a quarter turn
  logic [ANG_W-1:0]      tc_angle;
  logic [RES_SIDE_W-1:0] tc_side;
  ptap_res_t             tc_res;

  ptap_cordic #(
    .STAGES (CORDIC_STAGES),
    .SIDE_W (RES_SIDE_W)
  ) u_tilt_cordic (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (sq_valid),
    .in_ready  (sq_ready),
    .in_a      ({mount_height_r, 8'd0}),
    .in_b      (sq_root),
    .in_side   (sq_side),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_angle (tc_angle),
    .out_side  (tc_side)
  );

  assign tc_res      = ptap_res_t'(tc_side);
  assign out_pan     = tc_res.pan;
  assign out_clipped = tc_res.clip;
  assign out_tilt    = tc_angle;

endmodule

`default_nettype wire

// ===== design/ptap_checker.sv =====
// ptap_checker: port-level assertions for the pan/tilt core, bound to the top level.
// Depends on pan_tilt_angle_from_position_core.
`default_nettype none

module ptap_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [14:0] out_pan,
  input logic        [12:0] out_tilt,
  input logic               out_clipped
);

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // with the output side free every stage moves, so a request is always taken
  a_ready_flow: assert property (@(posedge clk) disable iff (!rst_n)
    out_ready |-> in_ready)
    else $error("request refused while output is free");

  a_tilt_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_tilt <= 13'd5760)
    else $error("tilt beyond a quarter turn");

  a_pan_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_pan <= 15'sd11520) && (out_pan >= -15'sd11520))
    else $error("pan beyond half a turn");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_pan) && $stable(out_tilt)
                                && $stable(out_clipped))
    else $error("stalled result changed");

endmodule

bind pan_tilt_angle_from_position_core ptap_checker u_ptap_checker (.*);

`default_nettype wire

// ===== dv/pan_tilt_angle_from_position_core_tb.sv =====
// pan_tilt_angle_from_position_core_tb: self-checking bench for the pan/tilt angle pipeline,
// with directed corner requests, random sweeps over several register settings and back-pressure.
// Depends on ptap_pkg and pan_tilt_angle_from_position_core only.
`timescale 1ns / 1ps

module pan_tilt_angle_from_position_core_tb;
  import ptap_pkg::*;

  localparam int     STAGES      = CORDIC_STAGES_DEF;
  localparam int     LATENCY     = 2 * STAGES + 30;
  localparam int     IDLE_LIMIT  = 4000;   // cycles with no request and no result accepted
  localparam int     REPORT_MAX  = 10;
  localparam int     HOLD_CYCLES = 300;    // long result stall, well beyond the pipeline depth
  localparam longint RIGHT_ANGLE = longint'(QUARTER);

  // atan(2^-i) in 1/16384 degree
  localparam longint ARCTAN_Q14 [0:23] = '{
    737280, 435242, 229970, 116736, 58595, 29326, 14667, 7334,
    3667, 1833, 917, 458, 229, 115, 57, 29,
    14, 7, 4, 2, 1, 0, 0, 0
  };

  typedef struct packed {
    logic signed [PAN_W-1:0] pan;
    logic [TILT_W-1:0]       tilt;
    logic                    clip;
  } angles_t;

  logic                    clk;
  logic                    rst_n;
  logic                    in_valid;
  logic                    in_ready;
  logic signed [POS_W-1:0] in_pos_x;
  logic signed [POS_W-1:0] in_pos_y;
  logic                    out_valid;
  logic                    out_ready;
  logic signed [PAN_W-1:0] out_pan;
  logic [TILT_W-1:0]       out_tilt;
  logic                    out_clipped;
  logic                    cfg_we;
  logic [CFG_IDX_W-1:0]    cfg_index;
  logic [CFG_DATA_W-1:0]   cfg_data;

  // our own copy of the register file, tracking every write
  logic [SCALE_W-1:0]      set_scale;
  logic signed [OFF_W-1:0] set_x_off;
  logic signed [OFF_W-1:0] set_y_off;
  logic [HGT_W-1:0]        set_height;

  angles_t expected_angles[$];

  bit tx_idle_on;
  bit rx_idle_on;
  int ready_hold;     // requested result stall, counted down by the receiver
  int failures;
  int requests_sent;
  int results_checked;
  int writes_done;
  int input_stalls;
  int idle_cycles;

  pan_tilt_angle_from_position_core #(
    .CORDIC_STAGES(STAGES)
  ) DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_pos_x   (in_pos_x),
    .in_pos_y   (in_pos_y),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_pan    (out_pan),
    .out_tilt   (out_tilt),
    .out_clipped(out_clipped),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // angle predictor
  // ---------------------------------------------------------------------------

  // pixel to ground metres in Q8.8: scale, round half up, remove offset, saturate
  function automatic longint ground_q88(input logic signed [POS_W-1:0] pix,
                                        input logic signed [OFF_W-1:0] off,
                                        output bit sat);
    longint v;
    v = ((longint'(pix) * longint'(set_scale) + 128) >>> 8) - longint'(off);
    sat = (v > 32767) || (v < -32768);
    if (v > 32767) v = 32767;
    else if (v < -32768) v = -32768;
    return v;
  endfunction

  // floor of the square root, one result bit at a time
  function automatic longint unsigned floor_root(input longint unsigned n);
    longint unsigned r;
    longint unsigned t;
    r = 0;
    for (int b = 25; b >= 0; b--) begin
      t = r | (64'd1 << b);
      if (t * t <= n) r = t;
    end
    return r;
  endfunction

  // vectoring rotation of (a, b), both non-negative; angle in 1/64 degree
  function automatic longint first_quadrant_angle(input longint a, input longint b);
    longint cx;
    longint cy;
    longint nx;
    longint z;
    if (b == 0) return 0;
    if (a == 0) return RIGHT_ANGLE;
    cx = a;
    cy = b;
    z  = 0;
    for (int i = 0; i < STAGES && i < 24; i++) begin
      if (cy >= 0) begin
        nx = cx + (cy >>> i);
        cy = cy - (cx >>> i);
        z += ARCTAN_Q14[i];
      end else begin
        nx = cx - (cy >>> i);
        cy = cy + (cx >>> i);
        z -= ARCTAN_Q14[i];
      end
      cx = nx;
    end
    z = (z + 128) >>> 8;
    if (z < 0) z = 0;
    if (z > RIGHT_ANGLE) z = RIGHT_ANGLE;
    return z;
  endfunction

  function automatic angles_t predict_angles(input logic signed [POS_W-1:0] px,
                                             input logic signed [POS_W-1:0] py);
    angles_t         res;
    bit              sat_x;
    bit              sat_y;
    longint          gx;
    longint          gy;
    longint          ax;
    longint          ay;
    longint          a;
    longint          pan;
    longint          tilt;
    longint unsigned rng;
    gx = ground_q88(px, set_x_off, sat_x);
    gy = ground_q88(py, set_y_off, sat_y);
    ax = (gx < 0) ? -gx : gx;
    ay = (gy < 0) ? -gy : gy;
    // the origin points straight along the y axis
    if (gx == 0 && gy == 0) begin
      pan = RIGHT_ANGLE;
    end else begin
      a = first_quadrant_angle(ax * 256, ay * 256);
      if (gx >= 0) pan = (gy < 0) ? -a : a;
      else pan = (gy < 0) ? a - 2 * RIGHT_ANGLE : 2 * RIGHT_ANGLE - a;
    end
    rng  = floor_root((ax * ax + ay * ay) << 16);
    tilt = (rng == 0) ? 0 : first_quadrant_angle(longint'(set_height) * 256, longint'(rng));
    res.pan  = pan[PAN_W-1:0];
    res.tilt = tilt[TILT_W-1:0];
    res.clip = sat_x | sat_y;
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // random choices
  // ---------------------------------------------------------------------------

  // mostly back to back, sometimes a short gap, rarely a long gap
  function automatic int idle_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 70);
  endfunction

  function automatic logic signed [POS_W-1:0] pick_position();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return POS_W'(int'($urandom_range(0, 8)) - 4);
      2:       return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
      3, 4, 5: return POS_W'($urandom);
      default: return POS_W'(int'($urandom_range(0, 4000)) - 2000);
    endcase
  endfunction

  function automatic logic [SCALE_W-1:0] pick_scale();
    case ($urandom_range(0, 5))
      0:       return '1;
      1:       return SCALE_W'($urandom);
      default: return SCALE_W'($urandom_range(100, 3000));
    endcase
  endfunction

  function automatic logic signed [OFF_W-1:0] pick_offset();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
      2:       return OFF_W'($urandom);
      default: return OFF_W'(int'($urandom_range(0, 5120)) - 2560);
    endcase
  endfunction

  function automatic logic [HGT_W-1:0] pick_height();
    case ($urandom_range(0, 5))
      0:       return 16'd1;
      1:       return 16'hffff;
      2:       return HGT_W'($urandom);
      default: return HGT_W'($urandom_range(256, 8192));
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // shared drivers
  // ---------------------------------------------------------------------------

  task automatic note_failure(input string what, input longint want, input longint got);
    failures++;
    if (failures <= REPORT_MAX)
      $display("[%0t] mismatch on %0s: expected %0d, got %0d", $time, what, want, got);
  endtask

  // offer one position request; valid stays up until it is taken
  task automatic send_position(input logic signed [POS_W-1:0] px,
                               input logic signed [POS_W-1:0] py);
    int gap;
    gap = tx_idle_on ? idle_length() : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_pos_x <= px;
    in_pos_y <= py;
    do begin
      @(posedge clk);
    end while (!in_ready);
    expected_angles.push_back(predict_angles(px, py));
    requests_sent++;
  endtask

  // sender goes quiet until every outstanding result has come back
  task automatic wait_for_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_angles.size() != 0) @(posedge clk);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_SCALE:        set_scale  = val[SCALE_W-1:0];
      CFG_X_OFFSET:     set_x_off  = val[OFF_W-1:0];
      CFG_Y_OFFSET:     set_y_off  = val[OFF_W-1:0];
      CFG_MOUNT_HEIGHT: set_height = val[HGT_W-1:0];
      default:          ;
    endcase
    writes_done++;
  endtask

  // registers only change once the pipeline has drained
  task automatic configure(input logic [SCALE_W-1:0] s, input logic signed [OFF_W-1:0] xo,
                           input logic signed [OFF_W-1:0] yo, input logic [HGT_W-1:0] h);
    wait_for_results();
    write_register(CFG_SCALE, CFG_DATA_W'(s));
    write_register(CFG_X_OFFSET, CFG_DATA_W'(xo));
    write_register(CFG_Y_OFFSET, CFG_DATA_W'(yo));
    write_register(CFG_MOUNT_HEIGHT, CFG_DATA_W'(h));
  endtask

  task automatic send_random(input int count);
    for (int n = 0; n < count; n++) send_position(pick_position(), pick_position());
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // reset register values: origin, the four half axes, the diagonals and the field extremes
  task automatic test_axes_and_origin();
    send_position(16'sd0, 16'sd0);
    send_position(16'sd0, 16'sd500);
    send_position(16'sd0, -16'sd500);
    send_position(-16'sd500, 16'sd0);
    send_position(16'sd500, 16'sd0);
    send_position(16'sd300, 16'sd300);
    send_position(-16'sd300, 16'sd300);
    send_position(-16'sd300, -16'sd300);
    send_position(16'sd300, -16'sd300);
    send_position(16'sh7fff, 16'sh7fff);
    send_position(16'sh8000, 16'sh8000);
    send_position(16'sh7fff, 16'sh8000);
    send_position(16'sh8000, 16'sh7fff);
    send_position(16'sd1, 16'sd0);
    send_position(16'sd0, -16'sd1);
  endtask

  // saturation from the offsets alone and from the largest scale, then scale zero
  task automatic test_saturation_limits();
    configure('1, 16'sh7fff, 16'sh8000, 16'hffff);
    send_position(16'sd0, 16'sd0);
    send_position(16'sd1, -16'sd1);
    send_position(16'sh8000, 16'sh7fff);
    configure(18'd256, 16'sh8000, 16'sh7fff, 16'd1);
    send_position(16'sd0, 16'sd0);
    send_position(16'sh7fff, 16'sh8000);
    configure('0, 16'sd0, 16'sd0, 16'd1);
    send_position(16'sd12345, -16'sd12345);
  endtask

  // a zero mount height tilts straight to the horizon unless the range is zero too
  task automatic test_zero_height();
    configure(SCALE_RST, 16'sd0, 16'sd0, '0);
    send_position(16'sd100, 16'sd50);
    send_position(16'sd0, 16'sd0);
    send_position(-16'sd1, 16'sd0);
  endtask

  // random positions over several random register settings, idling on both sides
  task automatic test_random_sweep();
    for (int phase = 0; phase < 4; phase++) begin
      configure(pick_scale(), pick_offset(), pick_offset(), pick_height());
      send_random(95);
    end
  endtask

  // long result stall while requests keep coming, so the pipeline backs up to the input
  task automatic test_backpressure();
    configure(SCALE_RST, pick_offset(), pick_offset(), pick_height());
    tx_idle_on = 1'b0;
    ready_hold = HOLD_CYCLES;
    send_random(150);
    wait_for_results();
    tx_idle_on = 1'b1;
  endtask

  // one request and one result every cycle, no idling anywhere
  task automatic test_full_rate();
    configure(SCALE_RST, 16'sd0, 16'sd0, HEIGHT_RST);
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    send_random(100);
    wait_for_results();
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
  endtask

  // ---------------------------------------------------------------------------
  // result side
  // ---------------------------------------------------------------------------

  // receiver: random stalls, plus a long hold when a test asks for one
  initial begin
    int wait_left;
    wait_left = 0;
    forever begin
      @(negedge clk);
      if (ready_hold > 0) begin
        out_ready <= 1'b0;
        ready_hold--;
      end else if (wait_left > 0) begin
        out_ready <= 1'b0;
        wait_left--;
      end else begin
        out_ready <= 1'b1;
        if (rx_idle_on) wait_left = idle_length();
      end
    end
  end

  // every accepted result against the oldest outstanding prediction
  always @(posedge clk) begin
    angles_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_angles.size() == 0) begin
        note_failure("result with no request outstanding, pan", 0, out_pan);
      end else begin
        want = expected_angles.pop_front();
        if (out_pan !== want.pan) note_failure("pan", want.pan, out_pan);
        if (out_tilt !== want.tilt) note_failure("tilt", want.tilt, out_tilt);
        if (out_clipped !== want.clip) note_failure("clipped", want.clip, out_clipped);
        results_checked++;
      end
    end
  end

  // watchdog: too long with neither a request nor a result taken means a hang
  always @(posedge clk) begin
    if (in_valid && !in_ready) input_stalls++;
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("[%0t] no progress for %0d cycles", $time, IDLE_LIMIT);
      $display("pan_tilt_angle_from_position_core_tb NOT OK");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------------------

  initial begin
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_pos_x   = '0;
    in_pos_y   = '0;
    out_ready  = 1'b0;
    cfg_we     = 1'b0;
    cfg_index  = CFG_SCALE;
    cfg_data   = '0;
    set_scale  = SCALE_RST;
    set_x_off  = '0;
    set_y_off  = '0;
    set_height = HEIGHT_RST;
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    ready_hold = 0;
    failures   = 0;
    idle_cycles     = 0;
    requests_sent   = 0;
    results_checked = 0;
    writes_done     = 0;
    input_stalls    = 0;

    // reset held, then released on a falling edge
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_axes_and_origin();
    test_saturation_limits();
    test_zero_height();
    test_random_sweep();
    test_backpressure();
    test_full_rate();

    // drain, then give any stray result time to show up
    wait_for_results();
    repeat (LATENCY + 20) @(posedge clk);
    if (expected_angles.size() != 0)
      note_failure("results still outstanding", 0, expected_angles.size());

    $display("covered %0d requests and %0d checked results over %0d register writes,",
             requests_sent, results_checked, writes_done);
    $display("including %0d cycles with the input held off by a full pipeline", input_stalls);
    if (failures == 0) begin
      $display("pan_tilt_angle_from_position_core_tb OK");
    end else begin
      $display("%0d failures", failures);
      $display("pan_tilt_angle_from_position_core_tb NOT OK");
    end
    $finish;
  end

endmodule
